FILE: rtl/gitd_pkg.sv
// Shared types, codes and constants for the gamepad idle timeout detector.
package gitd_pkg;

   localparam int unsigned AxisWidth   = 8;
   localparam int unsigned DpadWidth   = 4;
   localparam int unsigned ButtonWidth = 24;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CsrWidth    = 8;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned ReqDataWidth = 112;
   localparam int unsigned ReqUserWidth = 3;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [DpadWidth-1:0] DpadCentered = 4'd8;
   localparam logic [15:0]          MsPerMinute  = 16'd60000;
   localparam logic [CsrWidth-1:0]  AxisLowReset  = 8'd120;
   localparam logic [CsrWidth-1:0]  AxisHighReset = 8'd140;

   typedef enum logic [1:0] {
      CMD_NOTE  = 2'd0,
      CMD_RETRY = 2'd1,
      CMD_RESET = 2'd2
   } cmd_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_TIMEOUT   = 2'd0,
      REG_AXIS_LOW  = 2'd1,
      REG_AXIS_HIGH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0]   time_ms;
      logic [ButtonWidth-1:0] button_bits;
      logic [DpadWidth-1:0]   dpad_code;
      logic [AxisWidth-1:0]   right_trigger;
      logic [AxisWidth-1:0]   left_trigger;
      logic [AxisWidth-1:0]   right_stick_y;
      logic [AxisWidth-1:0]   right_stick_x;
      logic [AxisWidth-1:0]   left_stick_y;
      logic [AxisWidth-1:0]   left_stick_x;
   } report_type;

   typedef struct packed {
      logic is_neutral;
      logic disconnect_now;
   } result_type;

endpackage

FILE: rtl/gitd_neutral.sv
// Neutral report check: sticks in window, triggers released, d-pad centered, no buttons.
module gitd_neutral
   import gitd_pkg::*;
(
   input  report_type          report,
   input  logic [CsrWidth-1:0] axis_low,
   input  logic [CsrWidth-1:0] axis_high,
   output logic                is_neutral
);

   function automatic logic centered(input logic [AxisWidth-1:0] v,
                                     input logic [CsrWidth-1:0]  lo,
                                     input logic [CsrWidth-1:0]  hi);
      return (v >= lo) && (v <= hi);
   endfunction

   always_comb begin
      is_neutral = centered(report.left_stick_x,  axis_low, axis_high) &&
                   centered(report.left_stick_y,  axis_low, axis_high) &&
                   centered(report.right_stick_x, axis_low, axis_high) &&
                   centered(report.right_stick_y, axis_low, axis_high) &&
                   (report.left_trigger  == '0) &&
                   (report.right_trigger == '0) &&
                   (report.dpad_code == DpadCentered) &&
                   (report.button_bits == '0);
   end

endmodule

FILE: rtl/gitd_tracker.sv
// Idle tracker state and the one-shot disconnect decision.
module gitd_tracker
   import gitd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           command,
   input  logic                 full_report,
   input  logic                 is_neutral,
   input  logic [TimeWidth-1:0] now,
   input  logic [CsrWidth-1:0]  timeout_minutes,
   input  logic [TimeWidth-1:0] limit_ms,
   output result_type           result
);

   logic                 armed_ff, armed_in;
   logic [CsrWidth-1:0]  armed_minutes_ff, armed_minutes_in;
   logic [TimeWidth-1:0] last_time_ff, last_time_in;
   logic                 pending_ff, pending_in;
   logic [TimeWidth-1:0] idle_ms;

   assign idle_ms = now - last_time_ff;

   always_comb begin
      armed_in         = armed_ff;
      armed_minutes_in = armed_minutes_ff;
      last_time_in     = last_time_ff;
      pending_in       = pending_ff;
      result           = '0;
      unique case (cmd_type'(command))
         CMD_RETRY: begin
            pending_in = 1'b0;
         end
         CMD_RESET: begin
            armed_in         = 1'b0;
            armed_minutes_in = '0;
            last_time_in     = '0;
            pending_in       = 1'b0;
         end
         CMD_NOTE: begin
            if (full_report) begin
               result.is_neutral = is_neutral;
               if (timeout_minutes == '0) begin
                  armed_in         = 1'b0;
                  armed_minutes_in = '0;
                  last_time_in     = '0;
                  pending_in       = 1'b0;
               end else if (!armed_ff || (armed_minutes_ff != timeout_minutes)) begin
                  armed_in         = 1'b1;
                  armed_minutes_in = timeout_minutes;
                  last_time_in     = now;
                  pending_in       = 1'b0;
               end else if (!is_neutral) begin
                  last_time_in = now;
                  pending_in   = 1'b0;
               end else if (!pending_ff && (idle_ms > limit_ms)) begin
                  last_time_in          = now;
                  pending_in            = 1'b1;
                  result.disconnect_now = 1'b1;
               end
            end
         end
         default: begin
            // Unused command code: no state change, zero result.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         armed_minutes_ff <= '0;
         last_time_ff     <= '0;
         pending_ff       <= 1'b0;
      end else if (step) begin
         armed_ff         <= armed_in;
         armed_minutes_ff <= armed_minutes_in;
         last_time_ff     <= last_time_in;
         pending_ff       <= pending_in;
      end
   end

`ifndef SYNTHESIS
   a_disarmed_clear: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (armed_minutes_ff == '0) && !pending_ff)
      else $error("tracker disarmed but holds state");

   a_fire_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (step && result.disconnect_now) |=> pending_ff && (last_time_ff == $past(now)))
      else $error("disconnect did not set pending flag");

   a_fire_needs_neutral: assert property (@(posedge clock) disable iff (reset)
      result.disconnect_now |-> result.is_neutral && armed_ff && !pending_ff)
      else $error("disconnect raised on active or unarmed tracker");
`endif

endmodule

FILE: rtl/gamepad_idle_timeout_detector.sv
// Top level of the gamepad idle timeout detector: ports, settings, request and result registers.
//
// Channel  Direction  Handshake              Payload
// req_     in         req_tvalid/req_tready  req_tuser: command, full_report; req_tdata: report
// rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata: disconnect_now, is_neutral
// csr_     in         csr_we                 csr_index, csr_wdata
//
// Each request lands in an input register; once the output register is free, the neutral
// check and the tracker decide it and write the result to the output register, which drives
// rsp_tvalid.
// One request is accepted every cycle while the result channel is not stalled; the limit is
// the single tracker update per cycle, which the next request needs before it is decided.
// Reset is synchronous; it sets the settings to their reset values and clears the tracker and both valid flags.
// A stalled result stops the input register only when it is full as well, so the two
// registers together hold two requests while rsp_tready is low.
module gamepad_idle_timeout_detector
   import gitd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [1:0] command, [2] full_report
   input  logic [ReqUserWidth-1:0] req_tuser,
   // [7:0] left_stick_x, [15:8] left_stick_y, [23:16] right_stick_x,
   // [31:24] right_stick_y, [39:32] left_trigger, [47:40] right_trigger,
   // [51:48] dpad_code, [75:52] button_bits, [107:76] time_ms, [111:108] zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   // Result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] disconnect_now, [1] is_neutral, [7:2] zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   // Settings write port
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrWidth-1:0]     csr_wdata
);

   // Settings. The idle limit in milliseconds is worked out when the timeout is written,
   // which keeps the multiplier off the decision path.
   logic [CsrWidth-1:0]  timeout_ff;
   logic [CsrWidth-1:0]  axis_low_ff;
   logic [CsrWidth-1:0]  axis_high_ff;
   logic [TimeWidth-1:0] limit_ff;
   logic [23:0]          limit_product;

   assign limit_product = csr_wdata * MsPerMinute;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= '0;
         axis_low_ff  <= AxisLowReset;
         axis_high_ff <= AxisHighReset;
         limit_ff     <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_TIMEOUT: begin
               timeout_ff <= csr_wdata;
               limit_ff   <= TimeWidth'(limit_product);
            end
            REG_AXIS_LOW:  axis_low_ff  <= csr_wdata;
            REG_AXIS_HIGH: axis_high_ff <= csr_wdata;
            default: begin
               // Writes to the spare index are dropped.
            end
         endcase
      end
   end

   // Input register. It advances whenever the result register can take the result.
   logic                    in_valid_ff;
   logic [1:0]              in_command_ff;
   logic                    in_full_ff;
   report_type              in_report_ff;
   logic                    out_valid_ff;
   result_type              out_result_ff;
   logic                    decide;
   logic                    out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign decide     = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_command_ff <= req_tuser[1:0];
         in_full_ff    <= req_tuser[2];
         in_report_ff  <= report_type'(req_tdata[$bits(report_type)-1:0]);
      end
   end

   // Decision logic.
   logic       is_neutral;
   result_type result;

   gitd_neutral u_neutral (
      .report     (in_report_ff),
      .axis_low   (axis_low_ff),
      .axis_high  (axis_high_ff),
      .is_neutral (is_neutral)
   );

   gitd_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .step            (decide),
      .command         (in_command_ff),
      .full_report     (in_full_ff),
      .is_neutral      (is_neutral),
      .now             (in_report_ff.time_ms),
      .timeout_minutes (timeout_ff),
      .limit_ms        (limit_ff),
      .result          (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (decide) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-2){1'b0}}, out_result_ff.is_neutral,
                        out_result_ff.disconnect_now};

endmodule
